// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define GBTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define GBTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gbte_pkg.sv -----
// Types and constants of the gap-buffer text edit unit
`default_nettype none

package gbte_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int BYTE_W       = 8;
  localparam int INDEX_W      = 10;
  localparam int TAB_W        = 4;

  localparam logic [BYTE_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CODE_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_RETURN    = 8'd13;
  localparam logic [BYTE_W-1:0] CODE_SPACE     = 8'd32;

  localparam logic [TAB_W-1:0] TAB_MAX   = 4'd8;
  localparam logic [TAB_W-1:0] TAB_RESET = 4'd4;

  typedef enum logic [1:0] {
    KIND_TYPE  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTHING = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_MOVE_RD = 7'b0000010,
    S_MOVE_WR = 7'b0000100,
    S_EDIT    = 7'b0001000,
    S_TAB     = 7'b0010000,
    S_READ    = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ----- design/gap_buffer_text_edit_unit.sv -----
// Gap-buffer text edit unit: top level with control sequencer and text RAM
// One item in, one result out. Cursor moves and out-of-range reads go from idle
// straight to the finish state, an in-range read through a read state first. A
// typed character first walks the gap to the cursor, one byte per read-then-write
// pair through the single text RAM port pair, then makes the edit, or writes the
// spaces of a tab one by one. Results wait in an output register; the next item is
// taken as soon as the sequencer is back in idle. The text RAM needs no clearing after reset.
`default_nettype none

module gap_buffer_text_edit_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [9:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  out_status,
  output logic      [7:0]  out_read_byte,
  output logic      [10:0] out_cursor_position,
  output logic      [10:0] out_text_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);

  localparam int AW = gbte_pkg::ADDR_W;
  localparam int CW = gbte_pkg::CNT_W;
  localparam int BW = gbte_pkg::BYTE_W;
  localparam int TW = gbte_pkg::TAB_W;

  gbte_pkg::state_t  state_r, state_nxt;
  gbte_pkg::status_t status_r, status_nxt;
  gbte_pkg::kind_t   in_kind_e;

  logic [CW-1:0] gap_begin_r, gap_begin_nxt;
  logic [CW-1:0] gap_limit_r, gap_limit_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] length_r, length_nxt;
  logic [TW-1:0] tab_spaces_r;
  logic [TW-1:0] tab_cnt_r, tab_cnt_nxt;
  logic [BW-1:0] code_r, code_nxt;
  logic [BW-1:0] rbyte_r, rbyte_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [BW-1:0] out_rbyte_r;
  logic [CW-1:0] out_cursor_r;
  logic [CW-1:0] out_length_r;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [BW-1:0] ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [BW-1:0] ram_rd_data;

  logic          in_accept;
  logic          out_load;
  logic          move_back;
  logic          gap_full;
  logic [CW-1:0] gap_len;
  logic [CW-1:0] ridx;
  logic [CW-1:0] phys;
  logic [CW-1:0] gb_dec;
  logic [CW-1:0] gl_dec;
  logic [CW-1:0] gb_inc;
  logic [TW-1:0] tab_n;

  assign in_kind_e = gbte_pkg::kind_t'(in_kind);
  assign in_ready  = (state_r == gbte_pkg::S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == gbte_pkg::S_FIN) && (!out_valid_r || out_ready);

  assign gap_len   = gap_limit_r - gap_begin_r;
  assign ridx      = CW'(in_read_index);
  assign phys      = (ridx < gap_begin_r) ? ridx : ridx + gap_len;
  assign move_back = cursor_r < gap_begin_r;
  assign gap_full  = gap_begin_r >= gap_limit_r;
  assign gb_dec    = gap_begin_r - CW'(1);
  assign gl_dec    = gap_limit_r - CW'(1);
  assign gb_inc    = gap_begin_r + CW'(1);
  assign tab_n     = (tab_spaces_r > gbte_pkg::TAB_MAX) ? gbte_pkg::TAB_MAX : tab_spaces_r;

  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    gap_begin_nxt = gap_begin_r;
    gap_limit_nxt = gap_limit_r;
    cursor_nxt    = cursor_r;
    length_nxt    = length_r;
    tab_cnt_nxt   = tab_cnt_r;
    code_nxt      = code_r;
    rbyte_nxt     = rbyte_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = gap_begin_r[AW-1:0];
    ram_wr_data   = ram_rd_data;
    ram_rd_addr   = move_back ? gb_dec[AW-1:0] : gap_limit_r[AW-1:0];

    unique case (state_r)
      gbte_pkg::S_IDLE: begin
        ram_rd_addr = phys[AW-1:0];
        if (in_accept) begin
          status_nxt = gbte_pkg::ST_DONE;
          rbyte_nxt  = '0;
          code_nxt   = in_char_code;
          unique case (in_kind_e)
            gbte_pkg::KIND_TYPE: begin
              state_nxt = (cursor_r != gap_begin_r) ? gbte_pkg::S_MOVE_RD : gbte_pkg::S_EDIT;
            end
            gbte_pkg::KIND_LEFT: begin
              state_nxt = gbte_pkg::S_FIN;
              if (cursor_r != '0) begin
                cursor_nxt = cursor_r - CW'(1);
              end else begin
                status_nxt = gbte_pkg::ST_NOTHING;
              end
            end
            gbte_pkg::KIND_RIGHT: begin
              state_nxt = gbte_pkg::S_FIN;
              if (cursor_r < length_r) begin
                cursor_nxt = cursor_r + CW'(1);
              end else begin
                status_nxt = gbte_pkg::ST_NOTHING;
              end
            end
            gbte_pkg::KIND_READ: begin
              if (ridx < length_r) begin
                state_nxt = gbte_pkg::S_READ;
              end else begin
                status_nxt = gbte_pkg::ST_RANGE;
                state_nxt  = gbte_pkg::S_FIN;
              end
            end
            default: state_nxt = gbte_pkg::S_IDLE;
          endcase
        end
      end

      gbte_pkg::S_MOVE_RD: begin
        state_nxt = gbte_pkg::S_MOVE_WR;
      end

      // byte read last cycle lands on the other side of the gap
      gbte_pkg::S_MOVE_WR: begin
        ram_wr_en = 1'b1;
        if (move_back) begin
          ram_wr_addr   = gl_dec[AW-1:0];
          gap_begin_nxt = gb_dec;
          gap_limit_nxt = gl_dec;
          state_nxt     = (gb_dec == cursor_r) ? gbte_pkg::S_EDIT : gbte_pkg::S_MOVE_RD;
        end else begin
          ram_wr_addr   = gap_begin_r[AW-1:0];
          gap_begin_nxt = gb_inc;
          gap_limit_nxt = gap_limit_r + CW'(1);
          state_nxt     = (gb_inc == cursor_r) ? gbte_pkg::S_EDIT : gbte_pkg::S_MOVE_RD;
        end
      end

      gbte_pkg::S_EDIT: begin
        state_nxt = gbte_pkg::S_FIN;
        if (code_r == gbte_pkg::CODE_BACKSPACE) begin
          if (gap_begin_r != '0) begin
            gap_begin_nxt = gb_dec;
            length_nxt    = length_r - CW'(1);
            cursor_nxt    = gb_dec;
          end else begin
            status_nxt = gbte_pkg::ST_NOTHING;
          end
        end else if (gap_full) begin
          status_nxt = gbte_pkg::ST_FULL;
        end else if (code_r == gbte_pkg::CODE_TAB) begin
          if (tab_n == '0) begin
            status_nxt = gbte_pkg::ST_NOTHING;
          end else begin
            tab_cnt_nxt = tab_n;
            state_nxt   = gbte_pkg::S_TAB;
          end
        end else begin
          ram_wr_en     = 1'b1;
          ram_wr_data   = (code_r == gbte_pkg::CODE_RETURN) ? gbte_pkg::CODE_NEWLINE : code_r;
          gap_begin_nxt = gb_inc;
          length_nxt    = length_r + CW'(1);
          cursor_nxt    = gb_inc;
        end
      end

      gbte_pkg::S_TAB: begin
        priority if (tab_cnt_r == '0) begin
          state_nxt = gbte_pkg::S_FIN;
        end else if (gap_full) begin
          status_nxt = gbte_pkg::ST_FULL;
          state_nxt  = gbte_pkg::S_FIN;
        end else begin
          ram_wr_en     = 1'b1;
          ram_wr_data   = gbte_pkg::CODE_SPACE;
          gap_begin_nxt = gb_inc;
          length_nxt    = length_r + CW'(1);
          cursor_nxt    = gb_inc;
          tab_cnt_nxt   = tab_cnt_r - TW'(1);
        end
      end

      gbte_pkg::S_READ: begin
        rbyte_nxt = ram_rd_data;
        state_nxt = gbte_pkg::S_FIN;
      end

      gbte_pkg::S_FIN: begin
        if (out_load) begin
          state_nxt = gbte_pkg::S_IDLE;
        end
      end

      default: state_nxt = gbte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gbte_pkg::S_IDLE;
      gap_begin_r  <= '0;
      gap_limit_r  <= CW'(gbte_pkg::BUFFER_BYTES);
      cursor_r     <= '0;
      length_r     <= '0;
      tab_spaces_r <= gbte_pkg::TAB_RESET;
      tab_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gap_begin_r <= gap_begin_nxt;
      gap_limit_r <= gap_limit_nxt;
      cursor_r    <= cursor_nxt;
      length_r    <= length_nxt;
      tab_cnt_r   <= tab_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tab_spaces_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    code_r   <= code_nxt;
    rbyte_r  <= rbyte_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_rbyte_r  <= rbyte_r;
      out_cursor_r <= cursor_r;
      out_length_r <= length_r;
    end
  end

  gbte_ram #(
    .WIDTH (gbte_pkg::BYTE_W),
    .DEPTH (gbte_pkg::BUFFER_BYTES)
  ) u_text_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_byte       = out_rbyte_r;
  assign out_cursor_position = out_cursor_r;
  assign out_text_length     = out_length_r;

endmodule

`default_nettype wire

// ----- design/gbte_ram.sv -----
// Generic simple dual-port RAM with registered read
`default_nettype none

module gbte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/gbte_checker.sv -----
// Port-level checker for the gap-buffer text edit unit, with its bind
`default_nettype none

`include "assert_macros.svh"

module gbte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_kind,
  input wire logic [7:0]  in_char_code,
  input wire logic [9:0]  in_read_index,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_read_byte,
  input wire logic [10:0] out_cursor_position,
  input wire logic [10:0] out_text_length,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [3:0]  cfg_data
);

  // result valid, status, cursor and length hold while stalled
  `GBTE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_text_length) && $stable(out_cursor_position) && $stable(out_status), "result beat changed while stalled")

  `GBTE_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

  `GBTE_ASSERT(a_cursor_in_text, out_valid |-> out_cursor_position <= out_text_length, "cursor beyond text")

  `GBTE_ASSERT(a_byte_on_done, out_valid && (out_read_byte != 8'd0) |-> out_status == gbte_pkg::ST_DONE, "read byte with failing status")

  `GBTE_ASSERT(a_full_len, out_valid && (out_status == gbte_pkg::ST_FULL) |-> out_text_length == 11'(gbte_pkg::BUFFER_BYTES), "full status below capacity")

endmodule

bind gap_buffer_text_edit_unit gbte_checker u_gbte_checker (.*);

`default_nettype wire

// ----- test/gap_buffer_text_edit_unit_test.sv -----
// Testbench for the gap-buffer text edit unit: scoreboard class, driver tasks and top module
`timescale 1ns / 1ps

typedef struct packed {
  gbte_pkg::status_t                 status;
  logic [gbte_pkg::BYTE_W-1:0]       read_byte;
  logic [gbte_pkg::CNT_W-1:0]        cursor_position;
  logic [gbte_pkg::CNT_W-1:0]        text_length;
} edit_result_t;

class text_edit_scoreboard;
  logic [gbte_pkg::BYTE_W-1:0] text_mem [gbte_pkg::BUFFER_BYTES];
  int gap_lo;
  int gap_hi;
  int cursor;
  int length_held;
  int tab_count;
  int errors;
  edit_result_t pending_q[$];

  function void clear();
    gap_lo = 0;
    gap_hi = gbte_pkg::BUFFER_BYTES;
    cursor = 0;
    length_held = 0;
    tab_count = int'(gbte_pkg::TAB_RESET);
    errors = 0;
  endfunction

  function void move_gap();
    int gsize;
    int n;
    gsize = gap_hi - gap_lo;
    if (cursor < gap_lo) begin
      n = gap_lo - cursor;
      for (int i = n - 1; i >= 0; i--) text_mem[cursor + gsize + i] = text_mem[cursor + i];
      gap_lo = cursor;
      gap_hi = cursor + gsize;
    end else if (cursor > gap_lo) begin
      n = cursor - gap_lo;
      for (int i = 0; i < n; i++) text_mem[gap_lo + i] = text_mem[gap_hi + i];
      gap_lo = cursor;
      gap_hi = cursor + gsize;
    end
  endfunction

  function bit insert_byte(logic [gbte_pkg::BYTE_W-1:0] b);
    if (gap_lo >= gap_hi || gap_lo >= gbte_pkg::BUFFER_BYTES) return 1'b0;
    text_mem[gap_lo] = b;
    gap_lo++;
    length_held++;
    cursor = gap_lo;
    return 1'b1;
  endfunction

  function void note_item(gbte_pkg::kind_t kind, logic [gbte_pkg::BYTE_W-1:0] code,
                          logic [gbte_pkg::INDEX_W-1:0] idx);
    edit_result_t want;
    int spaces;
    int phys;
    want.status = gbte_pkg::ST_DONE;
    want.read_byte = '0;
    unique case (kind)
      gbte_pkg::KIND_TYPE: begin
        move_gap();
        if (code == gbte_pkg::CODE_BACKSPACE) begin
          if (gap_lo > 0) begin
            gap_lo--;
            length_held--;
            cursor = gap_lo;
          end else begin
            want.status = gbte_pkg::ST_NOTHING;
          end
        end else if (gap_lo >= gap_hi) begin
          want.status = gbte_pkg::ST_FULL;
        end else if (code == gbte_pkg::CODE_TAB) begin
          spaces = (tab_count > int'(gbte_pkg::TAB_MAX)) ? int'(gbte_pkg::TAB_MAX) : tab_count;
          if (spaces == 0) want.status = gbte_pkg::ST_NOTHING;
          repeat (spaces) if (!insert_byte(gbte_pkg::CODE_SPACE)) want.status = gbte_pkg::ST_FULL;
        end else if (!insert_byte(code == gbte_pkg::CODE_RETURN ? gbte_pkg::CODE_NEWLINE : code))
        begin
          want.status = gbte_pkg::ST_FULL;
        end
      end
      gbte_pkg::KIND_LEFT: begin
        if (cursor > 0) cursor--;
        else want.status = gbte_pkg::ST_NOTHING;
      end
      gbte_pkg::KIND_RIGHT: begin
        if (cursor < length_held) cursor++;
        else want.status = gbte_pkg::ST_NOTHING;
      end
      default: begin
        if (int'(idx) < length_held) begin
          phys = (int'(idx) < gap_lo) ? int'(idx) : int'(idx) + gap_hi - gap_lo;
          if (phys < gbte_pkg::BUFFER_BYTES) want.read_byte = text_mem[phys];
        end else begin
          want.status = gbte_pkg::ST_RANGE;
        end
      end
    endcase
    want.cursor_position = cursor[gbte_pkg::CNT_W-1:0];
    want.text_length = length_held[gbte_pkg::CNT_W-1:0];
    pending_q.push_back(want);
  endfunction

  task report(string msg);
    if (errors < 100) $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [1:0] st, logic [gbte_pkg::BYTE_W-1:0] rb,
                    logic [gbte_pkg::CNT_W-1:0] cur, logic [gbte_pkg::CNT_W-1:0] len);
    edit_result_t want;
    if (pending_q.size() == 0) begin
      report("result beat with nothing outstanding");
      return;
    end
    want = pending_q.pop_front();
    if (st !== want.status)
      report($sformatf("status %0d, want %0d", st, want.status));
    if (rb !== want.read_byte)
      report($sformatf("read_byte %0h, want %0h", rb, want.read_byte));
    if (cur !== want.cursor_position)
      report($sformatf("cursor %0d, want %0d", cur, want.cursor_position));
    if (len !== want.text_length)
      report($sformatf("length %0d, want %0d", len, want.text_length));
  endtask
endclass

module gap_buffer_text_edit_unit_test;

  localparam int BW = gbte_pkg::BYTE_W;
  localparam int IW = gbte_pkg::INDEX_W;
  localparam int CW = gbte_pkg::CNT_W;
  localparam int TW = gbte_pkg::TAB_W;

  logic           clk;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  logic [1:0]     in_kind = gbte_pkg::KIND_TYPE;
  logic [BW-1:0]  in_char_code = '0;
  logic [IW-1:0]  in_read_index = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [1:0]     out_status;
  logic [BW-1:0]  out_read_byte;
  logic [CW-1:0]  out_cursor_position;
  logic [CW-1:0]  out_text_length;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [TW-1:0]  cfg_data = '0;

  bit steady = 1'b0;
  int stall_left = 0;
  text_edit_scoreboard sb;

  gap_buffer_text_edit_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_char_code        (in_char_code),
    .in_read_index       (in_read_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_read_byte       (out_read_byte),
    .out_cursor_position (out_cursor_position),
    .out_text_length     (out_text_length),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin : rx_stall
    int roll;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      roll = int'($urandom_range(0, 99));
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= (roll < 95) ? int'($urandom_range(0, 2)) : int'($urandom_range(10, 40));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_status, out_read_byte, out_cursor_position, out_text_length);
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  task automatic send_edit(input gbte_pkg::kind_t k, input logic [BW-1:0] code,
                           input logic [IW-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_char_code <= code;
    in_read_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, code, idx);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic apply_tab_count(input logic [TW-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.tab_count = int'(v);
  endtask

  // random item mix, with walks: a run of cursor steps then a typed byte, so the gap travels far
  task automatic run_mix(input int items, input int tab_pct, input int bs_pct,
                         input int move_pct, input int read_pct, input bit fill);
    int i;
    int roll;
    int steps;
    gbte_pkg::kind_t k;
    logic [BW-1:0] code;
    logic [IW-1:0] idx;
    i = 0;
    while (fill ? (sb.length_held < gbte_pkg::BUFFER_BYTES) : (i < items)) begin
      steady = (i % 100) < 20;
      roll = int'($urandom_range(0, 99));
      code = BW'($urandom_range(0, 255));
      idx = IW'($urandom_range(0, 1023));
      k = gbte_pkg::KIND_TYPE;
      if (roll < 3) begin
        steps = int'($urandom_range(4, 12));
        k = ($urandom_range(0, 1) != 0) ? gbte_pkg::KIND_LEFT : gbte_pkg::KIND_RIGHT;
        repeat (steps) send_edit(k, code, idx);
        k = gbte_pkg::KIND_TYPE;
        code = BW'($urandom_range(32, 126));
      end else if (roll < 3 + tab_pct) begin
        code = gbte_pkg::CODE_TAB;
      end else if (roll < 3 + tab_pct + bs_pct) begin
        code = gbte_pkg::CODE_BACKSPACE;
      end else if (roll < 3 + tab_pct + bs_pct + move_pct) begin
        k = ($urandom_range(0, 1) != 0) ? gbte_pkg::KIND_LEFT : gbte_pkg::KIND_RIGHT;
      end else if (roll < 3 + tab_pct + bs_pct + move_pct + read_pct) begin
        k = gbte_pkg::KIND_READ;
        if (sb.length_held != 0 && $urandom_range(0, 3) != 0)
          idx = IW'($urandom_range(0, sb.length_held - 1));
      end else if ($urandom_range(0, 4) == 0) begin
        code = gbte_pkg::CODE_RETURN;
      end else if ($urandom_range(0, 1) != 0) begin
        code = BW'($urandom_range(32, 126));
      end
      send_edit(k, code, idx);
      i++;
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new;
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_edit(gbte_pkg::KIND_TYPE, gbte_pkg::CODE_BACKSPACE, 10'd0);
    send_edit(gbte_pkg::KIND_LEFT, 8'hff, 10'h3ff);
    send_edit(gbte_pkg::KIND_RIGHT, 8'h00, 10'd0);
    send_edit(gbte_pkg::KIND_READ, 8'h00, 10'd0);
    send_edit(gbte_pkg::KIND_READ, 8'hff, 10'h3ff);
    send_edit(gbte_pkg::KIND_TYPE, 8'h00, 10'h3ff);
    send_edit(gbte_pkg::KIND_TYPE, 8'hff, 10'd0);
    send_edit(gbte_pkg::KIND_TYPE, gbte_pkg::CODE_RETURN, 10'd0);
    send_edit(gbte_pkg::KIND_TYPE, gbte_pkg::CODE_TAB, 10'd0);
    send_edit(gbte_pkg::KIND_TYPE, 8'h41, 10'd0);
    for (int i = 0; i < 6; i++) send_edit(gbte_pkg::KIND_READ, 8'h00, i[IW-1:0]);
    send_edit(gbte_pkg::KIND_LEFT, 8'h00, 10'd0);
    send_edit(gbte_pkg::KIND_LEFT, 8'h00, 10'd0);
    send_edit(gbte_pkg::KIND_TYPE, 8'h5a, 10'd0);
    send_edit(gbte_pkg::KIND_RIGHT, 8'h00, 10'd0);
    send_edit(gbte_pkg::KIND_TYPE, gbte_pkg::CODE_BACKSPACE, 10'd0);
    send_edit(gbte_pkg::KIND_READ, 8'h00, 10'd7);
    send_edit(gbte_pkg::KIND_RIGHT, 8'h00, 10'd0);
    send_edit(gbte_pkg::KIND_RIGHT, 8'h00, 10'd0);
    apply_tab_count(4'd0);
    send_edit(gbte_pkg::KIND_TYPE, gbte_pkg::CODE_TAB, 10'd0);
    apply_tab_count(4'd15);
    send_edit(gbte_pkg::KIND_TYPE, gbte_pkg::CODE_TAB, 10'd0);

    run_mix(100, 12, 8, 20, 20, 1'b0);
    apply_tab_count(gbte_pkg::TAB_MAX);
    run_mix(0, 50, 3, 10, 10, 1'b1);
    run_mix(30, 20, 20, 20, 20, 1'b0);
    apply_tab_count(4'd0);
    run_mix(60, 15, 25, 20, 20, 1'b0);
    apply_tab_count(TW'($urandom_range(1, 7)));
    run_mix(60, 15, 10, 20, 20, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/gbte_pkg.sv
design/gbte_ram.sv
design/gap_buffer_text_edit_unit.sv
design/gbte_checker.sv
test/gap_buffer_text_edit_unit_test.sv
